// ===== hw/rtl/range_and_longest_prefix_search_macros.svh =====
// Assertion macros used by the range-AND search RTL.
`ifndef RANGE_AND_LONGEST_PREFIX_SEARCH_MACROS_SVH
`define RANGE_AND_LONGEST_PREFIX_SEARCH_MACROS_SVH

// same-cycle implication, checked outside reset
`define RALPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RALPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ralps_pkg.sv =====
// Types and constants of the range-AND longest-prefix search block.
package ralps_pkg;

    localparam int VAL_W        = 31;
    localparam int IDX_W        = 11;
    localparam int ST_W         = 2;
    localparam int CAPACITY_DEF = 1024;

    // slave tdata layout
    localparam int IN_VALUE_LSB = 0;
    localparam int IN_FIRST_BIT = VAL_W;
    localparam int IN_START_LSB = VAL_W + 1;
    localparam int IN_THR_LSB   = VAL_W + 1 + IDX_W;
    localparam int IN_TDATA_W   = ((2 * VAL_W + 1 + IDX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((IDX_W + 7) / 8) * 8;

    typedef enum logic {
        MODE_APPEND = 1'b0,
        MODE_QUERY  = 1'b1
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_FOUND = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

endpackage

// ===== hw/rtl/ralps_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module ralps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/range_and_longest_prefix_search.sv =====
// Range-AND longest-prefix search: AND segment tree in RAM, walked by a small sequencer.
// Append: writes the leaf, then updates the tree up to the root (one tree level per cycle) before ready returns.
// Query: walks the tree up and then down, one RAM read per step.
// Full and out-of-range answers skip the tree walk and go through S_OUT to the output register.
// One word in flight; a finished result waits in the output register while the next is taken.
// Sync active-low reset clears count, sequencer and output valid; the tree RAM is not cleared,
// since reads are bounded by the element count and no clearing pass is needed.
module range_and_longest_prefix_search
    import ralps_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // value[30:0], first_of_set[31], start_index[42:32], threshold[73:43], zero fill
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // mode[0]
    input  logic                   i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // end_index[10:0], zero fill
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // status[1:0]
    output logic [ST_W-1:0]        o_m_tuser
);

    localparam int LW     = $clog2(CAPACITY);
    localparam int LEAVES = 1 << LW;
    localparam int AW     = LW + 1;
    localparam int DEPTH  = 2 * LEAVES;
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int HW     = $clog2(LW + 1);
    localparam int SW     = CW + IDX_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LEAF  = 7'b0000010,
        S_UP    = 7'b0000100,
        S_CLIMB = 7'b0001000,
        S_CHK   = 7'b0010000,
        S_DESC  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_l, n_l;
    logic [HW-1:0]    r_h, n_h;
    logic [VAL_W-1:0] r_acc, n_acc;
    logic [VAL_W-1:0] r_thr, n_thr;
    logic [LW-1:0]    r_s, n_s;
    t_status          r_res_status, n_res_status;
    logic [IDX_W-1:0] r_res_end, n_res_end;
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status, n_out_status;
    logic [IDX_W-1:0] r_out_end, n_out_end;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    // input fields
    t_mode            in_mode;
    logic [VAL_W-1:0] in_value;
    logic             in_first;
    logic [IDX_W-1:0] in_start;
    logic [VAL_W-1:0] in_thr;

    assign in_mode  = t_mode'(i_s_tuser);
    assign in_value = i_s_tdata[IN_VALUE_LSB +: VAL_W];
    assign in_first = i_s_tdata[IN_FIRST_BIT];
    assign in_start = i_s_tdata[IN_START_LSB +: IDX_W];
    assign in_thr   = i_s_tdata[IN_THR_LSB +: VAL_W];

    // shared compare unit: current node against running AND, threshold and count bound
    logic [VAL_W-1:0] w_and;
    logic [AW:0]      w_node_end;
    logic [AW:0]      w_limit;
    logic             w_pass;
    logic [AW-1:0]    w_l_inc;
    logic             w_top;

    assign w_and      = r_acc & ram_rdata;
    assign w_node_end = ({1'b0, r_l} + (AW+1)'(1)) << r_h;
    assign w_limit    = (AW+1)'(r_count) + (AW+1)'(LEAVES);
    assign w_pass     = (w_node_end <= w_limit) && (w_and >= r_thr);
    assign w_l_inc    = r_l + AW'(1);
    // wrapped to a power of two: the walk passed the right edge of the tree
    assign w_top      = (w_l_inc & (w_l_inc - AW'(1))) == '0;

    ralps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_tree (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    always_comb begin
        logic [CW-1:0]       cnt;
        logic [SW-1:0]       st_w;
        logic [SW-1:0]       cnt_w;
        logic [SW-1:0]       s_w;
        logic [AW-1:0]       np;
        logic [AW-1:0]       l_new;
        logic                fin;
        logic [LW:0]         fp;
        logic [LW+IDX_W:0]   fp_ext;

        n_state      = r_state;
        n_count      = r_count;
        n_l          = r_l;
        n_h          = r_h;
        n_acc        = r_acc;
        n_thr        = r_thr;
        n_s          = r_s;
        n_res_status = r_res_status;
        n_res_end    = r_res_end;
        ram_we       = 1'b0;
        ram_waddr    = r_l;
        ram_wdata    = r_acc;
        ram_raddr    = r_l;
        fin          = 1'b0;
        fp           = '0;
        cnt          = '0;
        st_w         = SW'(in_start);
        cnt_w        = SW'(r_count);
        s_w          = st_w - SW'(1);
        np           = r_l >> 1;
        l_new        = w_pass ? w_l_inc : r_l;

        n_out_valid  = r_out_valid & ~i_m_tready;
        n_out_status = r_out_status;
        n_out_end    = r_out_end;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (in_mode == MODE_APPEND) begin
                        cnt     = in_first ? '0 : r_count;
                        n_count = cnt;
                        if (cnt >= CW'(CAPACITY)) begin
                            n_res_status = ST_FULL;
                            n_res_end    = '0;
                            n_state      = S_OUT;
                        end else begin
                            n_acc   = in_value;
                            n_l     = {1'b1, cnt[LW-1:0]};
                            n_state = S_LEAF;
                        end
                    end else if (st_w == '0 || st_w > cnt_w) begin
                        n_res_status = ST_RANGE;
                        n_res_end    = '0;
                        n_state      = S_OUT;
                    end else begin
                        n_s     = s_w[LW-1:0];
                        n_l     = {1'b1, s_w[LW-1:0]};
                        n_h     = '0;
                        n_acc   = '1;
                        n_thr   = in_thr;
                        n_state = S_CLIMB;
                    end
                end
            end
            S_LEAF: begin
                ram_we    = 1'b1;
                ram_waddr = r_l;
                ram_wdata = r_acc;
                ram_raddr = r_l ^ AW'(1);
                n_count   = r_count + CW'(1);
                n_state   = S_UP;
            end
            S_UP: begin
                // sibling of r_l is on the read port
                ram_we    = 1'b1;
                ram_waddr = np;
                ram_wdata = w_and;
                ram_raddr = np ^ AW'(1);
                n_acc     = w_and;
                n_l       = np;
                if (np == AW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_CLIMB: begin
                if (!r_l[0]) begin
                    n_l = r_l >> 1;
                    n_h = r_h + HW'(1);
                end else begin
                    ram_raddr = r_l;
                    n_state   = S_CHK;
                end
            end
            S_CHK: begin
                if (w_pass) begin
                    n_acc = w_and;
                    if (w_top) begin
                        fin = 1'b1;
                        fp  = (LW+1)'(LEAVES);
                    end else begin
                        n_l     = w_l_inc;
                        n_state = S_CLIMB;
                    end
                end else if (r_h == '0) begin
                    fin = 1'b1;
                    fp  = {1'b0, r_l[LW-1:0]};
                end else begin
                    n_l       = r_l << 1;
                    n_h       = r_h - HW'(1);
                    ram_raddr = r_l << 1;
                    n_state   = S_DESC;
                end
            end
            S_DESC: begin
                if (w_pass) begin
                    n_acc = w_and;
                end
                if (r_h == '0) begin
                    fin = 1'b1;
                    fp  = {1'b0, l_new[LW-1:0]};
                end else begin
                    n_l       = l_new << 1;
                    n_h       = r_h - HW'(1);
                    ram_raddr = l_new << 1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_end    = r_res_end;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // fp is the first leaf that fails (or the count), so the answer ends just before it
        fp_ext = (LW+IDX_W+1)'(fp);
        if (fin) begin
            n_state = S_OUT;
            if (fp == {1'b0, r_s}) begin
                n_res_status = ST_NONE;
                n_res_end    = '0;
            end else begin
                n_res_status = ST_FOUND;
                n_res_end    = fp_ext[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l          <= n_l;
        r_h          <= n_h;
        r_acc        <= n_acc;
        r_thr        <= n_thr;
        r_s          <= n_s;
        r_res_status <= n_res_status;
        r_res_end    <= n_res_end;
        r_out_status <= n_out_status;
        r_out_end    <= n_out_end;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_end);
    assign o_m_tuser  = r_out_status;

`include "range_and_longest_prefix_search_macros.svh"

    `RALPS_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "element count above capacity")
    `RALPS_ASSERT_NOW(a_leaf_room, i_clk, i_rst_n, r_state == S_LEAF, r_count < CW'(CAPACITY), "leaf write with store full")
    `RALPS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state != S_IDLE, "word accepted but sequencer stayed idle")
    `RALPS_ASSERT_NOW(a_walk_level, i_clk, i_rst_n, r_state == S_CHK || r_state == S_DESC, r_h <= HW'(LW), "tree walk level above root")

endmodule

// ===== tb/range_and_longest_prefix_search_test.sv =====
// Testbench for the range-AND longest-prefix search block: random and directed words, checked against a predictor.
module range_and_longest_prefix_search_test;
    import ralps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 850;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_PRINTS   = 20;

    typedef struct {
        t_status          status;
        logic [IDX_W-1:0] end_index;
    } t_answer;

    // Tracks the loaded elements and the answers still owed by the block.
    class and_search_scoreboard;
        logic [VAL_W-1:0] loaded_vals [CAP];
        int unsigned      loaded;
        t_answer          answers_due [$];
        int               errors;

        function new();
            loaded = 0;
            errors = 0;
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        task report_mismatch(input string what);
            errors++;
            if (errors <= MAX_PRINTS) begin
                $display("mismatch at %0t: %s", $realtime, what);
            end
        endtask

        // Accepted input word: update the element store, queue the answer if one is due.
        function void take_word(input t_mode m, input logic [IN_TDATA_W-1:0] d);
            logic [VAL_W-1:0] val;
            logic [VAL_W-1:0] thr;
            logic [VAL_W-1:0] acc;
            logic [IDX_W-1:0] start;
            int unsigned      s;
            int unsigned      last;
            t_answer          a;
            val         = d[IN_VALUE_LSB +: VAL_W];
            start       = d[IN_START_LSB +: IDX_W];
            thr         = d[IN_THR_LSB +: VAL_W];
            a.end_index = '0;
            if (m == MODE_APPEND) begin
                if (d[IN_FIRST_BIT]) begin
                    loaded = 0;
                end
                if (loaded >= CAP) begin
                    a.status = ST_FULL;
                    answers_due.push_back(a);
                end else begin
                    loaded_vals[loaded] = val;
                    loaded++;
                end
            end else if (start == 0 || start > loaded) begin
                a.status = ST_RANGE;
                answers_due.push_back(a);
            end else begin
                s = start - 1;
                if (loaded_vals[s] < thr) begin
                    a.status = ST_NONE;
                end else begin
                    // AND only loses bits as the range grows: stop at the first drop
                    acc  = loaded_vals[s];
                    last = s;
                    for (int unsigned i = s + 1; i < loaded; i++) begin
                        acc &= loaded_vals[i];
                        if (acc < thr) break;
                        last = i;
                    end
                    a.status    = ST_FOUND;
                    a.end_index = IDX_W'(last + 1);
                end
                answers_due.push_back(a);
            end
        endfunction

        task check_answer(input logic [ST_W-1:0] st, input logic [OUT_TDATA_W-1:0] d);
            t_answer a;
            if (answers_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word: status %0d end %0d", st, d));
                return;
            end
            a = answers_due.pop_front();
            if (st !== a.status) begin
                report_mismatch($sformatf("status %0d, want %0d", st, a.status));
            end
            if (d[IDX_W-1:0] !== a.end_index) begin
                report_mismatch($sformatf("end_index %0d, want %0d", d[IDX_W-1:0], a.end_index));
            end
            if (d[OUT_TDATA_W-1:IDX_W] !== '0) begin
                report_mismatch($sformatf("tdata fill bits not zero: %h", d));
            end
        endtask
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   i_s_tuser  = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [ST_W-1:0]        o_m_tuser;

    and_search_scoreboard sb;
    logic [VAL_W-1:0]     set_vals [$];
    int                   words_sent  = 0;
    int                   burst_left  = 1;
    bit                   drain_req   = 1'b0;
    int                   idle_cycles = 0;
    int                   rx_style    = 0;
    int                   rx_left     = 0;

    range_and_longest_prefix_search #(.CAPACITY(CAP)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // receiver: picks a new random stall pattern each time the current one runs out
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = $urandom_range(0, 3);
            rx_left  = $urandom_range(20, 300);
        end
        rx_left--;
        case (rx_style)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= 1'($urandom_range(0, 1));
            2:       i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= (rx_left % 40) >= 30;  // long stall, short window
        endcase
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_answer(o_m_tuser, o_m_tdata);
        end
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_word(input logic [VAL_W-1:0] val,
                                                        input logic first,
                                                        input logic [IDX_W-1:0] start,
                                                        input logic [VAL_W-1:0] thr);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[IN_VALUE_LSB +: VAL_W] = val;
        d[IN_FIRST_BIT]          = first;
        d[IN_START_LSB +: IDX_W] = start;
        d[IN_THR_LSB +: VAL_W]   = thr;
        return d;
    endfunction

    // mostly all-ones with one bit knocked out, usually a low one, so ANDs survive over long ranges
    function automatic logic [VAL_W-1:0] rand_elem();
        int pick;
        int sh;
        pick = $urandom_range(0, 15);
        sh   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, VAL_W - 1) : $urandom_range(0, 7);
        case (pick)
            0, 1:    return VAL_W'($urandom);
            2:       return '0;
            3, 4:    return '1;
            default: return ~(VAL_W'(1) << sh);
        endcase
    endfunction

    task automatic push_word(input t_mode m, input logic [IN_TDATA_W-1:0] d);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= m;
        i_s_tdata  <= d;
        do @(posedge i_clk); while (!o_s_tready);
        sb.take_word(m, d);
        words_sent++;
        burst_left--;
        if (drain_req || burst_left <= 0) begin
            i_s_tvalid <= 1'b0;
            if (drain_req) begin
                drain_req = 1'b0;
                do @(posedge i_clk); while (sb.pending() > 0);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // other-mode fields carry junk; the block must ignore them
    task automatic append_elem(input logic [VAL_W-1:0] val, input logic first);
        if (first) set_vals.delete();
        if (set_vals.size() < CAP) set_vals.push_back(val);
        push_word(MODE_APPEND, pack_word(val, first, IDX_W'($urandom), VAL_W'($urandom)));
    endtask

    task automatic run_query(input logic [IDX_W-1:0] start, input logic [VAL_W-1:0] thr);
        push_word(MODE_QUERY, pack_word(VAL_W'($urandom), 1'($urandom), start, thr));
    endtask

    // thresholds near the AND of a real range make the answer land anywhere in the set
    task automatic random_query();
        int               n;
        int               s;
        int               k;
        logic [VAL_W-1:0] acc;
        logic [VAL_W-1:0] thr;
        logic [IDX_W-1:0] start;
        n = set_vals.size();
        case ($urandom_range(0, 19))
            0:       start = '0;
            1:       start = IDX_W'($urandom_range(n + 1, 2047));
            2:       start = IDX_W'($urandom);
            default: start = (n == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(1, n));
        endcase
        thr = VAL_W'($urandom);
        if (start >= 1 && start <= n) begin
            s   = start - 1;
            k   = $urandom_range(0, n - 1 - s);
            acc = set_vals[s];
            for (int i = s + 1; i <= s + k; i++) acc &= set_vals[i];
            case ($urandom_range(0, 5))
                0, 1:    thr = acc;
                2:       thr = acc + 1'b1;
                3:       thr = acc - VAL_W'($urandom_range(0, 3));
                4:       thr = '0;
                default: ;
            endcase
        end
        run_query(start, thr);
    endtask

    task automatic run_set();
        int target;
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        if ($urandom_range(0, 7) == 0) random_query();
        append_elem(rand_elem(), 1'b1);
        while (set_vals.size() < target) begin
            if ($urandom_range(0, 9) < 4) begin
                append_elem(rand_elem(), $urandom_range(0, 40) == 0);
            end else begin
                random_query();
            end
        end
        repeat ($urandom_range(2, 10)) random_query();
        if ($urandom_range(0, 5) == 0) drain_req = 1'b1;
    endtask

    // loads the store to capacity, then overflows it, queries the full store and starts a new set
    task automatic fill_store();
        append_elem(rand_elem(), 1'b1);
        while (set_vals.size() < CAP) begin
            if ($urandom_range(0, 19) == 0) begin
                random_query();
            end else begin
                append_elem(rand_elem(), 1'b0);
            end
        end
        repeat (3) append_elem(rand_elem(), 1'b0);
        run_query(IDX_W'(CAP), '0);
        run_query(IDX_W'(CAP + 1), '0);
        run_query(IDX_W'(1), '0);
        repeat (10) random_query();
        append_elem(rand_elem(), 1'b1);
    endtask

    initial begin
        int rand_base;
        int fill_base;
        bit fill_done;
        sb        = new();
        fill_done = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extremes, found, none and out-of-range answers
        run_query(IDX_W'(1), '0);
        append_elem(31'h7FFF_FFFF, 1'b1);
        append_elem(31'h7FFF_FFFF, 1'b0);
        append_elem(31'h7FFF_FFF0, 1'b0);
        append_elem(31'h0000_0000, 1'b0);
        append_elem(31'h4000_0000, 1'b0);
        run_query(IDX_W'(0), '0);
        run_query(IDX_W'(6), '0);
        run_query(11'h7FF, 31'h7FFF_FFFF);
        run_query(IDX_W'(1), 31'h7FFF_FFFF);
        run_query(IDX_W'(1), '0);
        run_query(IDX_W'(4), 31'h0000_0001);
        run_query(IDX_W'(4), '0);
        run_query(IDX_W'(5), 31'h4000_0000);
        run_query(IDX_W'(5), 31'h4000_0001);
        drain_req = 1'b1;
        run_query(IDX_W'(3), 31'h7FFF_FFF0);
        append_elem(31'h0000_0005, 1'b1);
        run_query(IDX_W'(2), '0);
        run_query(IDX_W'(1), 31'h0000_0005);
        run_query(IDX_W'(1), 31'h0000_0006);

        rand_base = words_sent;
        while (words_sent - rand_base < RANDOM_ITEMS) begin
            if (!fill_done && words_sent - rand_base >= 200) begin
                fill_base = words_sent;
                fill_store();
                fill_done = 1'b1;
                rand_base += words_sent - fill_base;
            end else begin
                run_set();
            end
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
